@@ rtl/core/bdac_pkg.sv @@
// Package: shared types, codes and constants of the button debounce counter unit.
`timescale 1ns / 1ps

package bdac_pkg;

    localparam int COUNT_WIDTH = 8;
    localparam int CFG_AW      = 5;
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 16;

    localparam logic [7:0] RST_RANGE_MIN = 8'd0;
    localparam logic [7:0] RST_RANGE_MAX = 8'd16;
    localparam logic [7:0] RST_PRESS     = 8'd15;
    localparam logic [7:0] RST_RELEASE   = 8'd20;
    localparam logic [7:0] RST_REPEAT    = 8'd30;

    localparam logic [3:0] CODE_STEP = 4'd4;
    localparam logic [3:0] CODE_NEXT = 4'd8;
    localparam logic [1:0] LEVELS_RELEASED = 2'b11;

    typedef enum logic [2:0] {
        REG_RANGE_MIN = 3'd0,
        REG_RANGE_MAX = 3'd1,
        REG_PRESS     = 3'd2,
        REG_RELEASE   = 3'd3,
        REG_REPEAT    = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_EDGE       = 3'd0,
        OP_TICK       = 3'd1,
        OP_SET_VALUE  = 3'd2,
        OP_CLR_NEXT   = 3'd3,
        OP_CLR_UPDATE = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        PH_REST    = 4'b0001,
        PH_PRESS   = 4'b0010,
        PH_HELD    = 4'b0100,
        PH_RELEASE = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] range_min;
        logic [7:0] range_max;
        logic [7:0] press_ticks;
        logic [7:0] rel_ticks;
        logic [7:0] rpt_ticks;
    } cfg_t;

    typedef struct packed {
        logic [7:0] new_value;
        logic [1:0] button_levels;
        logic [3:0] pending_buttons;
        logic [2:0] operation;
    } item_t;

    typedef struct packed {
        logic       edge_taken;
        logic [1:0] phase;
        logic       update_flag;
        logic       next_flag;
        logic [7:0] shown_value;
    } result_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        unique case (ph)
            PH_REST:    code = 2'd0;
            PH_PRESS:   code = 2'd1;
            PH_HELD:    code = 2'd2;
            PH_RELEASE: code = 2'd3;
            default:    code = 2'd0;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/core/bdac_cfg.sv @@
// APB register file holding the range, guard and repeat settings.
`timescale 1ns / 1ps

module bdac_cfg
    import bdac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg,
    output logic              offset_clr
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);

    always_comb
    begin
        cfg_next   = cfg_reg;
        offset_clr = 1'b0;
        if (wr_en)
        begin
            unique case (idx)
                REG_RANGE_MIN:
                begin
                    cfg_next.range_min = pwdata[7:0];
                    offset_clr         = 1'b1;
                end
                REG_RANGE_MAX:
                begin
                    cfg_next.range_max = pwdata[7:0];
                    offset_clr         = 1'b1;
                end
                REG_PRESS:   cfg_next.press_ticks = pwdata[7:0];
                REG_RELEASE: cfg_next.rel_ticks   = pwdata[7:0];
                REG_REPEAT:  cfg_next.rpt_ticks   = pwdata[7:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_min   <= RST_RANGE_MIN;
            cfg_reg.range_max   <= RST_RANGE_MAX;
            cfg_reg.press_ticks <= RST_PRESS;
            cfg_reg.rel_ticks   <= RST_RELEASE;
            cfg_reg.rpt_ticks   <= RST_REPEAT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_RANGE_MIN: prdata = {24'd0, cfg_reg.range_min};
            REG_RANGE_MAX: prdata = {24'd0, cfg_reg.range_max};
            REG_PRESS:     prdata = {24'd0, cfg_reg.press_ticks};
            REG_RELEASE:   prdata = {24'd0, cfg_reg.rel_ticks};
            REG_REPEAT:    prdata = {24'd0, cfg_reg.rpt_ticks};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/bdac_step.sv @@
// Debounce phase machine, tick counter, counter value and flags for one item.
`timescale 1ns / 1ps

module bdac_step
    import bdac_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_en,
    input  item_t   item,
    input  cfg_t    cfg,
    input  logic    offset_clr,
    output result_t res
);

    phase_t                 phase_reg, phase_next;
    logic [7:0]             tick_reg, tick_next;
    logic [3:0]             latched_reg, latched_next;
    logic [COUNT_WIDTH-1:0] offset_reg, offset_next;
    logic                   next_reg, next_next;
    logic                   update_reg, update_next;
    logic                   taken;

    logic [7:0]             span;
    logic [7:0]             tick_inc;
    logic                   act;
    logic [3:0]             act_code;
    logic [7:0]             clamped;
    logic [7:0]             shown_sum;

    // inverted range gives a span of zero
    assign span     = (cfg.range_max >= cfg.range_min) ? (cfg.range_max - cfg.range_min) : 8'd0;
    assign tick_inc = tick_reg + 8'd1;

    always_comb
    begin
        if (item.new_value < cfg.range_min)
            clamped = cfg.range_min;
        else if (item.new_value > cfg.range_max)
            clamped = cfg.range_max;
        else
            clamped = item.new_value;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        latched_next = latched_reg;
        offset_next  = offset_reg;
        next_next    = next_reg;
        update_next  = update_reg;
        taken        = 1'b0;
        act          = 1'b0;
        act_code     = latched_reg;

        unique case (item.operation)
            OP_EDGE:
            begin
                if (phase_reg == PH_REST)
                begin
                    latched_next = item.pending_buttons;
                    act          = 1'b1;
                    act_code     = item.pending_buttons;
                    tick_next    = 8'd0;
                    phase_next   = PH_PRESS;
                    taken        = 1'b1;
                end
            end
            OP_TICK:
            begin
                unique case (phase_reg)
                    PH_PRESS:
                    begin
                        if (tick_reg == cfg.press_ticks)
                        begin
                            phase_next = PH_HELD;
                            tick_next  = 8'd0;
                        end
                        else
                            tick_next = tick_inc;
                    end
                    PH_HELD:
                    begin
                        if (item.button_levels != LEVELS_RELEASED)
                        begin
                            if (tick_inc == cfg.rpt_ticks)
                            begin
                                act       = 1'b1;
                                tick_next = 8'd0;
                            end
                            else
                                tick_next = tick_inc;
                        end
                        else
                        begin
                            tick_next  = 8'd0;
                            phase_next = PH_RELEASE;
                        end
                    end
                    PH_RELEASE:
                    begin
                        if (tick_reg == cfg.rel_ticks)
                            phase_next = PH_REST;
                        else
                            tick_next = tick_inc;
                    end
                    default: phase_next = phase_reg;
                endcase
            end
            OP_SET_VALUE:
            begin
                if (cfg.range_max < cfg.range_min)
                    offset_next = '0;
                else
                    offset_next = COUNT_WIDTH'(clamped - cfg.range_min);
            end
            OP_CLR_NEXT:   next_next   = 1'b0;
            OP_CLR_UPDATE: update_next = 1'b0;
            default:       taken       = 1'b0;
        endcase

        if (act)
        begin
            update_next = 1'b1;
            if (act_code == CODE_STEP)
            begin
                if (offset_reg >= COUNT_WIDTH'(span))
                    offset_next = '0;
                else
                    offset_next = offset_reg + COUNT_WIDTH'(1);
            end
            else if (act_code == CODE_NEXT)
                next_next = 1'b1;
        end
    end

    assign shown_sum = 8'(offset_next) + cfg.range_min;

    assign res.shown_value = shown_sum;
    assign res.next_flag   = next_next;
    assign res.update_flag = update_next;
    assign res.phase       = phase_code(phase_next);
    assign res.edge_taken  = taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_REST;
            tick_reg    <= 8'd0;
            latched_reg <= 4'd0;
            offset_reg  <= '0;
            next_reg    <= 1'b0;
            update_reg  <= 1'b0;
        end
        else
        begin
            if (step_en)
            begin
                phase_reg   <= phase_next;
                tick_reg    <= tick_next;
                latched_reg <= latched_next;
                next_reg    <= next_next;
                update_reg  <= update_next;
            end
            // a range write restarts the counter at the minimum
            if (offset_clr)
                offset_reg <= '0;
            else if (step_en)
                offset_reg <= offset_next;
        end
    end

    a_offset_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg <= COUNT_WIDTH'(span))
        else $error("counter offset beyond range span");

    a_clr_offset: assert property (@(posedge clk) disable iff (!rst_n)
        offset_clr |=> offset_reg == '0)
        else $error("range write did not restart the counter");

    a_taken_press: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && res.edge_taken) |=> phase_reg == PH_PRESS && tick_reg == 8'd0)
        else $error("accepted edge did not enter press guard");

    a_update_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(update_reg) |-> $past(step_en))
        else $error("update flag set without a transfer");

endmodule

@@ rtl/core/button_debounce_autorepeat_counter_unit.sv @@
// Top level: stream input register, step logic, result register and APB settings.
// An input item passes the input register, the step logic and the result register in turn.
// Throughput: one item per cycle unless the output stalls; the step is combinational.
// s_axis_tready drops only while both registers are full and m_axis_tready is low.
// Reset (rst_n, asynchronous, active low): phase rest, counts, value and flags zero,
// settings to their defaults; both stream stages empty.
`timescale 1ns / 1ps

module button_debounce_autorepeat_counter_unit
    import bdac_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pending_buttons[3:0], button_levels[5:4], new_value[13:6], zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation[2:0]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // shown_value[7:0], next_flag[8], update_flag[9], phase[11:10], edge_taken[12], zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_AW-1:0]      paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    logic    advance;
    result_t res;
    cfg_t    cfg;
    logic    offset_clr;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_item_reg <= item_t'({s_axis_tdata[$bits(item_t)-IN_TUSER_W-1:0], s_axis_tuser});
        if (advance)
            out_res_reg <= res;
    end

    bdac_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cfg        (cfg),
        .offset_clr (offset_clr)
    );

    bdac_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .item       (in_item_reg),
        .cfg        (cfg),
        .offset_clr (offset_clr),
        .res        (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, out_res_reg};

endmodule
